// File: rtl/tgad_pkg.sv
// Shared types and constants for the TGA true-colour decoder.
// No dependencies; every other file of the block imports it.
package tgad_pkg;

  localparam int unsigned HdrIdxW = 5;
  localparam int unsigned SkipW   = 22;   // id length + colour-map bytes, up to 2097375
  localparam int unsigned PixCntW = 32;

  // Header byte offsets
  localparam logic [HdrIdxW-1:0] HDR_ID_LEN    = 5'd0;
  localparam logic [HdrIdxW-1:0] HDR_TYPE      = 5'd2;
  localparam logic [HdrIdxW-1:0] HDR_CMLEN_LO  = 5'd5;
  localparam logic [HdrIdxW-1:0] HDR_CMLEN_HI  = 5'd6;
  localparam logic [HdrIdxW-1:0] HDR_CM_BITS   = 5'd7;
  localparam logic [HdrIdxW-1:0] HDR_SKIP_CALC = 5'd8;
  localparam logic [HdrIdxW-1:0] HDR_W_LO      = 5'd12;
  localparam logic [HdrIdxW-1:0] HDR_W_HI      = 5'd13;
  localparam logic [HdrIdxW-1:0] HDR_H_LO      = 5'd14;
  localparam logic [HdrIdxW-1:0] HDR_H_HI      = 5'd15;
  localparam logic [HdrIdxW-1:0] HDR_DEPTH     = 5'd16;
  localparam logic [HdrIdxW-1:0] HDR_LAST      = 5'd17;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;
  localparam logic [4:0] BPP_RGB  = 5'd3;
  localparam logic [4:0] BPP_RGBA = 5'd4;
  localparam int unsigned RunFlagBit = 7;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_PIX = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  // Decoded header, from the header unit to the rest of the block
  typedef struct packed {
    logic [15:0]        width;
    logic [15:0]        height;
    logic               is_rle;
    logic               alpha;
    logic               fmt_ok;
    logic               empty;
    logic               skip_zero;
    logic               skip_last;
    logic [PixCntW-1:0] pix_total;
  } hdr_t;

  // One decoded pixel beat from the pixel unit
  typedef struct packed {
    logic       emit;
    logic       done;
    logic       need_packet;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] count;
  } pix_t;

endpackage

// File: rtl/tgad_header.sv
// Header unit: byte counter, capture of the used header fields, format check,
// skip length and pixel total. Depends on tgad_pkg.
module tgad_header import tgad_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hdr_beat_i,
  input  logic       sof_i,
  input  logic       skip_beat_i,
  input  logic [7:0] data_byte_i,
  output logic       hdr_done_o,
  output hdr_t       hdr_o
);

  logic [HdrIdxW-1:0] idx_q, idx_d, idx_eff;
  logic [SkipW-1:0]   skip_q, skip_d, skip_calc;
  logic [7:0]         id_len_q, type_q, cm_bits_q, depth_q;
  logic [15:0]        cm_len_q, width_q, height_q;
  logic [8:0]         entry_sum;
  logic [5:0]         entry_bytes;

  assign idx_eff    = sof_i ? '0 : idx_q;
  assign hdr_done_o = hdr_beat_i && (idx_eff == HDR_LAST);

  // Round each colour-map entry up to whole bytes
  assign entry_sum   = {1'b0, cm_bits_q} + 9'd7;
  assign entry_bytes = entry_sum[8:3];
  assign skip_calc   = {{(SkipW-8){1'b0}}, id_len_q} +
                       SkipW'(cm_len_q) * SkipW'(entry_bytes);

  always_comb begin
    idx_d  = idx_q;
    skip_d = skip_q;
    if (hdr_beat_i) begin
      idx_d = (idx_eff == HDR_LAST) ? '0 : idx_eff + 1'b1;
      if (idx_eff == HDR_SKIP_CALC) begin
        skip_d = skip_calc;
      end
    end else if (skip_beat_i) begin
      skip_d = skip_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      skip_q <= '0;
    end else begin
      idx_q  <= idx_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_beat_i) begin
      case (idx_eff)
        HDR_ID_LEN:   id_len_q        <= data_byte_i;
        HDR_TYPE:     type_q          <= data_byte_i;
        HDR_CMLEN_LO: cm_len_q[7:0]   <= data_byte_i;
        HDR_CMLEN_HI: cm_len_q[15:8]  <= data_byte_i;
        HDR_CM_BITS:  cm_bits_q       <= data_byte_i;
        HDR_W_LO:     width_q[7:0]    <= data_byte_i;
        HDR_W_HI:     width_q[15:8]   <= data_byte_i;
        HDR_H_LO:     height_q[7:0]   <= data_byte_i;
        HDR_H_HI:     height_q[15:8]  <= data_byte_i;
        HDR_DEPTH:    depth_q         <= data_byte_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    hdr_o.width     = width_q;
    hdr_o.height    = height_q;
    hdr_o.is_rle    = (type_q == TYPE_RLE);
    hdr_o.alpha     = (depth_q[7:3] == BPP_RGBA);
    hdr_o.fmt_ok    = ((type_q == TYPE_RAW) || (type_q == TYPE_RLE)) &&
                      ((depth_q[7:3] == BPP_RGB) || (depth_q[7:3] == BPP_RGBA));
    hdr_o.empty     = (width_q == 16'd0) || (height_q == 16'd0);
    hdr_o.skip_zero = (skip_q == '0);
    hdr_o.skip_last = (skip_q == SkipW'(1));
    hdr_o.pix_total = width_q * height_q;
  end

endmodule

// File: rtl/tgad_pixel.sv
// Pixel unit: packet header decode, pixel byte assembly, run clipping and
// the count of pixels left in the image. Depends on tgad_pkg.
module tgad_pixel import tgad_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hdr_load_i,
  input  logic       pkt_beat_i,
  input  logic       data_beat_i,
  input  logic [7:0] data_byte_i,
  input  hdr_t       hdr_i,
  output pix_t       pix_o
);

  logic [7:0]         pkt_rem_q, pkt_rem_d;
  logic               pkt_run_q, pkt_run_d;
  logic [1:0]         pidx_q, pidx_d;
  logic [PixCntW-1:0] pix_rem_q, pix_rem_d, pix_rem_sub;
  logic [23:0]        asm_q;
  logic               last_byte, is_run;
  logic [7:0]         count;
  logic [7:0]         pkt_rem_after;

  assign last_byte = pidx_q == (hdr_i.alpha ? 2'd3 : 2'd2);
  assign is_run    = hdr_i.is_rle && pkt_run_q;

  always_comb begin
    if (is_run) begin
      count         = (pix_rem_q < {{(PixCntW-8){1'b0}}, pkt_rem_q}) ?
                      pix_rem_q[7:0] : pkt_rem_q;
      pkt_rem_after = 8'd0;
    end else begin
      count         = 8'd1;
      pkt_rem_after = (pkt_rem_q != 8'd0) ? pkt_rem_q - 8'd1 : 8'd0;
    end
  end

  assign pix_rem_sub = pix_rem_q - {{(PixCntW-8){1'b0}}, count};

  always_comb begin
    pix_o.emit        = data_beat_i && last_byte;
    pix_o.done        = (pix_rem_sub == '0);
    pix_o.need_packet = hdr_i.is_rle && (pkt_rem_after == 8'd0);
    pix_o.red         = hdr_i.alpha ? asm_q[23:16] : data_byte_i;
    pix_o.green       = asm_q[15:8];
    pix_o.blue        = asm_q[7:0];
    pix_o.alpha       = hdr_i.alpha ? data_byte_i : 8'd0;
    pix_o.count       = count;
  end

  always_comb begin
    pkt_rem_d = pkt_rem_q;
    pkt_run_d = pkt_run_q;
    pidx_d    = pidx_q;
    pix_rem_d = pix_rem_q;
    if (hdr_load_i) begin
      pkt_rem_d = 8'd0;
      pkt_run_d = 1'b0;
      pidx_d    = 2'd0;
      pix_rem_d = hdr_i.pix_total;
    end else if (pkt_beat_i) begin
      pkt_run_d = data_byte_i[RunFlagBit];
      pkt_rem_d = {1'b0, data_byte_i[6:0]} + 8'd1;
      pidx_d    = 2'd0;
    end else if (data_beat_i) begin
      if (last_byte) begin
        pidx_d    = 2'd0;
        pkt_rem_d = pkt_rem_after;
        pix_rem_d = pix_rem_sub;
      end else begin
        pidx_d = pidx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_rem_q <= '0;
      pkt_run_q <= 1'b0;
      pidx_q    <= '0;
      pix_rem_q <= '0;
    end else begin
      pkt_rem_q <= pkt_rem_d;
      pkt_run_q <= pkt_run_d;
      pidx_q    <= pidx_d;
      pix_rem_q <= pix_rem_d;
    end
  end

  // Lower pixel bytes; each is rewritten before the pixel that reads it
  always_ff @(posedge clk_i) begin
    if (data_beat_i && !last_byte) begin
      case (pidx_q)
        2'd0:    asm_q[7:0]   <= data_byte_i;
        2'd1:    asm_q[15:8]  <= data_byte_i;
        2'd2:    asm_q[23:16] <= data_byte_i;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tga_rle_image_decoder.sv
// Top level of the TGA true-colour decoder: parse phase control and the
// result register. Depends on tgad_pkg, tgad_header and tgad_pixel.
//
// Feed the file one byte per beat, with start_of_file_i high on the first
// byte of each file; that byte restarts the parse wherever it stands. The
// decoder takes one byte every cycle: each byte only updates small counters
// and the header fields, and a result, when the byte completes one, sits in
// the output register from the cycle after the byte is accepted. in_ready_o stays
// high while the output register is empty or being drained, so the stream
// stalls only when the result side stalls. After the 18 header bytes comes
// one result: header info (width, height, has_alpha; last set for an empty
// image) or an error (image type not 2/10, or depth outside 24 to 39 bits),
// after which bytes are dropped until the next start of file. The ID field
// and the colour map, at whole bytes per entry, are skipped. Pixels then come
// out as RGB(A) results with a repeat count of 1 for raw pixels or up to 128
// for a run, clipped so the image ends exactly at width times height pixels;
// last marks that final result and later bytes are dropped.
module tga_rle_image_decoder import tgad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [7:0]  repeat_count_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        has_alpha_o,
  output logic        last_o
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PACKET = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [2:0] phase_q, phase_d, phase_eff;
  logic       beat;
  logic       hdr_beat, skip_beat, pkt_beat, data_beat;
  logic       hdr_done, hdr_load;
  hdr_t       hdr;
  pix_t       pix;

  logic        out_valid_q, out_valid_d;
  logic        produce;
  kind_e       kind_d, kind_q;
  logic [7:0]  red_d, red_q, green_d, green_q, blue_d, blue_q, alpha_d, alpha_q;
  logic [7:0]  count_d, count_q;
  logic [15:0] width_d, width_q, height_d, height_q;
  logic        has_alpha_d, has_alpha_q, last_d, last_q;

  // Accept while the result register is empty or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign beat       = in_valid_i && in_ready_o;

  // Start of file overrides the stored phase for this very byte
  assign phase_eff = start_of_file_i ? PH_HEADER : phase_q;
  assign hdr_beat  = beat && (phase_eff == PH_HEADER);
  assign skip_beat = beat && (phase_eff == PH_SKIP);
  assign pkt_beat  = beat && (phase_eff == PH_PACKET);
  assign data_beat = beat && (phase_eff == PH_DATA);
  assign hdr_load  = hdr_done && hdr.fmt_ok;

  tgad_header u_header (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hdr_beat_i  (hdr_beat),
    .sof_i       (start_of_file_i),
    .skip_beat_i (skip_beat),
    .data_byte_i (data_byte_i),
    .hdr_done_o  (hdr_done),
    .hdr_o       (hdr)
  );

  tgad_pixel u_pixel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hdr_load_i  (hdr_load),
    .pkt_beat_i  (pkt_beat),
    .data_beat_i (data_beat),
    .data_byte_i (data_byte_i),
    .hdr_i       (hdr),
    .pix_o       (pix)
  );

  // Advance the parse phase
  always_comb begin
    phase_d = phase_q;
    if (beat) begin
      phase_d = phase_eff;
      case (phase_eff)
        PH_HEADER: begin
          if (hdr_done) begin
            if (!hdr.fmt_ok || hdr.empty) begin
              phase_d = PH_DONE;
            end else if (!hdr.skip_zero) begin
              phase_d = PH_SKIP;
            end else begin
              phase_d = hdr.is_rle ? PH_PACKET : PH_DATA;
            end
          end
        end
        PH_SKIP: begin
          if (hdr.skip_last) begin
            phase_d = hdr.is_rle ? PH_PACKET : PH_DATA;
          end
        end
        PH_PACKET: phase_d = PH_DATA;
        PH_DATA: begin
          if (pix.emit) begin
            if (pix.done) begin
              phase_d = PH_DONE;
            end else if (pix.need_packet) begin
              phase_d = PH_PACKET;
            end
          end
        end
        PH_DONE: phase_d = PH_DONE;
        default: phase_d = PH_DONE;
      endcase
    end
  end

  // Build the result of this byte, if it completes one
  always_comb begin
    produce     = hdr_done || pix.emit;
    kind_d      = KIND_HDR;
    red_d       = 8'd0;
    green_d     = 8'd0;
    blue_d      = 8'd0;
    alpha_d     = 8'd0;
    count_d     = 8'd0;
    width_d     = 16'd0;
    height_d    = 16'd0;
    has_alpha_d = 1'b0;
    last_d      = 1'b0;
    if (hdr_done) begin
      if (!hdr.fmt_ok) begin
        kind_d = KIND_ERR;
        last_d = 1'b1;
      end else begin
        kind_d      = KIND_HDR;
        width_d     = hdr.width;
        height_d    = hdr.height;
        has_alpha_d = hdr.alpha;
        last_d      = hdr.empty;
      end
    end else begin
      kind_d      = KIND_PIX;
      red_d       = pix.red;
      green_d     = pix.green;
      blue_d      = pix.blue;
      alpha_d     = pix.alpha;
      count_d     = pix.count;
      has_alpha_d = hdr.alpha;
      last_d      = pix.done;
    end
  end

  // Hold the result until taken; a new one may load in the same cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if (beat && produce) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && produce) begin
      kind_q      <= kind_d;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      alpha_q     <= alpha_d;
      count_q     <= count_d;
      width_q     <= width_d;
      height_q    <= height_d;
      has_alpha_q <= has_alpha_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign alpha_o        = alpha_q;
  assign repeat_count_o = count_q;
  assign image_width_o  = width_q;
  assign image_height_o = height_q;
  assign has_alpha_o    = has_alpha_q;
  assign last_o         = last_q;

endmodule
